[design/uff_pkg.sv]
// uff_pkg: shared types and constants of the serial port queue block
// transaction structs, event opcodes, event classes, register indexes
// no dependencies
`timescale 1ns / 1ps

package uff_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int OPCODE_W  = 3;
  localparam int LERR_W    = 3;
  localparam int ERR_W     = 4;
  localparam int LEVEL_W   = 7;
  localparam int THRESH_W  = 7;
  localparam int CFG_IDX_W = 3;

  // event opcodes as they arrive on the input port
  localparam logic [OPCODE_W-1:0] OP_LINE_BYTE = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_HOST_READ = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_HOST_WRITE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TX_DONE   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FLUSH     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RX_THROTTLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_OBEY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_FLOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_XON_CODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_CODE   = 3'd5;

  // register reset values
  localparam logic [BYTE_W-1:0]   XON       = 8'd17;
  localparam logic [BYTE_W-1:0]   XOFF      = 8'd19;
  localparam logic [THRESH_W-1:0] RX0THRESH = 7'd16;

  // error flag bit of a receive overflow
  localparam int ERR_OVERFLOW_BIT = 3;

  // event class after decode
  typedef enum logic [2:0] {
    K_LINE  = 3'd0,
    K_READ  = 3'd1,
    K_WRITE = 3'd2,
    K_DONE  = 3'd3,
    K_FLUSH = 3'd4,
    K_NOP   = 3'd5
  } kind_t;

  // input transaction
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   data_byte;
    logic [LERR_W-1:0]   line_errors;
    logic                cts_level;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               read_valid;
    logic [BYTE_W-1:0]  send_byte;
    logic               send_valid;
    logic               write_accepted;
    logic               rts_level;
    logic               tx_is_paused;
    logic               rx_is_paused;
    logic [ERR_W-1:0]   error_flags;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } result_t;

  // classified event handed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LERR_W-1:0] line_errors;
    logic              cts_level;
  } cmd_t;

endpackage

[design/uff_ram.sv]
// uff_ram: generic single write port ram with registered read
// used for the receive and transmit rings; no dependencies
`timescale 1ns / 1ps

module uff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/uff_front.sv]
// uff_front: accepts input transactions, decodes the opcode into an event class
// and holds them in a two entry queue for the back end; depends on uff_pkg
`timescale 1ns / 1ps

module uff_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  uff_pkg::item_t item,
  output logic           cmd_valid,
  output uff_pkg::cmd_t  cmd,
  input  logic           cmd_take
);

  uff_pkg::cmd_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  uff_pkg::cmd_t decoded;
  logic          do_push;
  logic          do_pop;

  // opcode decode
  always_comb begin
    decoded.data_byte   = item.data_byte;
    decoded.line_errors = item.line_errors;
    decoded.cts_level   = item.cts_level;
    unique case (item.opcode)
      uff_pkg::OP_LINE_BYTE:  decoded.kind = uff_pkg::K_LINE;
      uff_pkg::OP_HOST_READ:  decoded.kind = uff_pkg::K_READ;
      uff_pkg::OP_HOST_WRITE: decoded.kind = uff_pkg::K_WRITE;
      uff_pkg::OP_TX_DONE:    decoded.kind = uff_pkg::K_DONE;
      uff_pkg::OP_FLUSH:      decoded.kind = uff_pkg::K_FLUSH;
      default:                decoded.kind = uff_pkg::K_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[design/uff_back.sv]
// uff_back: executes classified events against the rings and flow control state,
// holds configuration registers and a two entry result queue
// depends on uff_pkg and uff_ram
`timescale 1ns / 1ps

module uff_back #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  uff_pkg::cmd_t                        cmd,
  output logic                                 cmd_take,
  output logic                                 empty,
  input  logic                                 pop,
  output uff_pkg::result_t                     result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [uff_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [uff_pkg::BYTE_W-1:0]           cfg_data
);

  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int ThrW  = uff_pkg::THRESH_W;
  localparam int SumW  = ((RX_CW > ThrW) ? RX_CW : ThrW) + 1;
  localparam int LvlW  = uff_pkg::LEVEL_W;
  localparam int ByteW = uff_pkg::BYTE_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic             rx_throttle_enable;
  logic             tx_obey_enable;
  logic             software_flow_mode;
  logic [ThrW-1:0]  rx_threshold;
  logic [ByteW-1:0] xon_code;
  logic [ByteW-1:0] xoff_code;

  // ring and flow control state
  logic [RX_PW-1:0] rx_head, rx_head_next;
  logic [RX_PW-1:0] rx_tail, rx_tail_next;
  logic [RX_CW-1:0] rx_fill, rx_fill_next;
  logic [TX_PW-1:0] tx_head, tx_head_next;
  logic [TX_PW-1:0] tx_tail, tx_tail_next;
  logic [TX_CW-1:0] tx_fill, tx_fill_next;
  logic             first_char_busy, first_char_busy_next;
  logic [ByteW-1:0] pending_flow_byte, pending_flow_byte_next;
  logic             pending_valid, pending_valid_next;
  logic             rx_pause_flag, rx_pause_flag_next;
  logic             tx_pause_flag, tx_pause_flag_next;
  logic             rts_state, rts_state_next;
  logic [uff_pkg::ERR_W-1:0] sticky_errors, sticky_errors_next;

  // event being executed
  uff_pkg::cmd_t    cur;

  // ring ports
  logic             rx_we, tx_we;
  logic [ByteW-1:0] rx_rdata, tx_rdata;

  // result queue
  uff_pkg::result_t res_slot [2];
  uff_pkg::result_t res_d;
  logic             res_wr, res_rd;
  logic [1:0]       res_cnt;
  logic             res_push, res_pop;

  // event evaluation helpers
  logic             near_full;
  logic             rx_full;
  logic             tx_nearly_full;
  logic             blocked;
  logic             stored;
  logic [RX_PW-1:0] rx_tail_inc, rx_head_inc;
  logic [TX_PW-1:0] tx_tail_inc, tx_head_inc;

  uff_ram #(.WIDTH(ByteW), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail),
    .wdata (cur.data_byte),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  uff_ram #(.WIDTH(ByteW), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail),
    .wdata (cur.data_byte),
    .raddr (tx_head),
    .rdata (tx_rdata)
  );

  // configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_throttle_enable <= 1'b0;
      tx_obey_enable     <= 1'b0;
      software_flow_mode <= 1'b0;
      rx_threshold       <= uff_pkg::RX0THRESH;
      xon_code           <= uff_pkg::XON;
      xoff_code          <= uff_pkg::XOFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uff_pkg::CFG_RX_THROTTLE: rx_throttle_enable <= cfg_data[0];
        uff_pkg::CFG_TX_OBEY:     tx_obey_enable     <= cfg_data[0];
        uff_pkg::CFG_SW_FLOW:     software_flow_mode <= cfg_data[0];
        uff_pkg::CFG_RX_THRESH:   rx_threshold       <= cfg_data[ThrW-1:0];
        uff_pkg::CFG_XON_CODE:    xon_code           <= cfg_data;
        uff_pkg::CFG_XOFF_CODE:   xoff_code          <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: idle launches the ring reads, exec updates state and queues the result
  assign cmd_take = (state == S_IDLE) && cmd_valid && (res_cnt != 2'd2);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd_take) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
  end

  // pointer increments with wrap at the ring depth
  assign rx_tail_inc = (rx_tail == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
  assign rx_head_inc = (rx_head == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;
  assign tx_head_inc = (tx_head == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;

  assign near_full      = (SumW'(rx_fill) + SumW'(rx_threshold)) >= SumW'(RX_DEPTH);
  assign rx_full        = (rx_fill == RX_CW'(RX_DEPTH));
  assign tx_nearly_full = (tx_fill >= TX_CW'(TX_DEPTH - 1));

  // event execution
  always_comb begin
    rx_head_next           = rx_head;
    rx_tail_next           = rx_tail;
    rx_fill_next           = rx_fill;
    tx_head_next           = tx_head;
    tx_tail_next           = tx_tail;
    tx_fill_next           = tx_fill;
    first_char_busy_next   = first_char_busy;
    pending_flow_byte_next = pending_flow_byte;
    pending_valid_next     = pending_valid;
    rx_pause_flag_next     = rx_pause_flag;
    tx_pause_flag_next     = tx_pause_flag;
    rts_state_next         = rts_state;
    sticky_errors_next     = sticky_errors;
    rx_we                  = 1'b0;
    tx_we                  = 1'b0;
    blocked                = 1'b0;
    stored                 = 1'b1;
    res_d                  = '0;

    unique case (cur.kind)
      uff_pkg::K_LINE: begin
        // pause the partner when the ring nears full
        if (rx_throttle_enable && near_full) begin
          if (software_flow_mode) begin
            if (!rx_pause_flag) begin
              rx_pause_flag_next = 1'b1;
              if (tx_fill != '0 || first_char_busy) begin
                pending_flow_byte_next = xoff_code;
                pending_valid_next     = 1'b1;
              end else begin
                first_char_busy_next = 1'b1;
                res_d.send_byte      = xoff_code;
                res_d.send_valid     = 1'b1;
              end
            end
          end else begin
            rts_state_next = 1'b0;
          end
        end
        sticky_errors_next = sticky_errors | {1'b0, cur.line_errors};
        // flow bytes from the partner
        if (software_flow_mode && tx_obey_enable) begin
          if (cur.data_byte == xon_code) begin
            tx_pause_flag_next = 1'b0;
            stored             = 1'b0;
          end else if (cur.data_byte == xoff_code) begin
            tx_pause_flag_next = 1'b1;
            stored             = 1'b0;
          end
        end
        if (stored) begin
          if (rx_full) begin
            sticky_errors_next[uff_pkg::ERR_OVERFLOW_BIT] = 1'b1;
          end else begin
            rx_we        = 1'b1;
            rx_tail_next = rx_tail_inc;
            rx_fill_next = rx_fill + 1'b1;
          end
        end
      end

      uff_pkg::K_READ: begin
        if (rx_fill != '0) begin
          res_d.read_byte  = rx_rdata;
          res_d.read_valid = 1'b1;
          rx_head_next     = rx_head_inc;
          rx_fill_next     = rx_fill - 1'b1;
        end
        // resume the partner once drained to the threshold
        if (rx_throttle_enable && (SumW'(rx_fill_next) <= SumW'(rx_threshold))) begin
          if (software_flow_mode) begin
            if (rx_pause_flag) begin
              if (tx_fill != '0 || first_char_busy) begin
                pending_flow_byte_next = xon_code;
                pending_valid_next     = 1'b1;
              end else begin
                first_char_busy_next = 1'b1;
                res_d.send_byte      = xon_code;
                res_d.send_valid     = 1'b1;
              end
              rx_pause_flag_next = 1'b0;
            end
          end else begin
            rts_state_next = 1'b1;
          end
        end
      end

      uff_pkg::K_WRITE: begin
        if (tx_obey_enable) begin
          blocked = software_flow_mode ? tx_pause_flag : !cur.cts_level;
        end
        if (tx_nearly_full || first_char_busy) begin
          blocked = 1'b1;
        end
        if (!blocked) begin
          res_d.write_accepted = 1'b1;
          if (tx_fill != '0) begin
            tx_we        = 1'b1;
            tx_tail_next = tx_tail_inc;
            tx_fill_next = tx_fill + 1'b1;
          end else begin
            first_char_busy_next = 1'b1;
            if (pending_valid) begin
              // held flow byte goes first, data waits in the ring
              res_d.send_byte        = pending_flow_byte;
              res_d.send_valid       = 1'b1;
              pending_valid_next     = 1'b0;
              pending_flow_byte_next = '0;
              tx_we                  = 1'b1;
              tx_tail_next           = tx_tail_inc;
              tx_fill_next           = tx_fill + 1'b1;
            end else begin
              res_d.send_byte  = cur.data_byte;
              res_d.send_valid = 1'b1;
            end
          end
        end
      end

      uff_pkg::K_DONE: begin
        first_char_busy_next = 1'b0;
        if (pending_valid) begin
          res_d.send_byte        = pending_flow_byte;
          res_d.send_valid       = 1'b1;
          pending_valid_next     = 1'b0;
          pending_flow_byte_next = '0;
        end else if (tx_fill != '0) begin
          res_d.send_byte  = tx_rdata;
          res_d.send_valid = 1'b1;
          tx_head_next     = tx_head_inc;
          tx_fill_next     = tx_fill - 1'b1;
        end
      end

      uff_pkg::K_FLUSH: begin
        rx_head_next           = '0;
        rx_tail_next           = '0;
        rx_fill_next           = '0;
        tx_head_next           = '0;
        tx_tail_next           = '0;
        tx_fill_next           = '0;
        first_char_busy_next   = 1'b0;
        pending_flow_byte_next = '0;
        pending_valid_next     = 1'b0;
        sticky_errors_next     = '0;
        rx_pause_flag_next     = 1'b0;
        tx_pause_flag_next     = 1'b0;
        if (rx_throttle_enable) begin
          if (software_flow_mode) begin
            rx_pause_flag_next = 1'b1;
          end else begin
            rts_state_next = 1'b1;
          end
        end
      end

      default: ;
    endcase

    // state report
    res_d.rts_level    = rts_state_next;
    res_d.tx_is_paused = tx_pause_flag_next;
    res_d.rx_is_paused = rx_pause_flag_next;
    res_d.error_flags  = sticky_errors_next;
    res_d.rx_level     = LvlW'(rx_fill_next);
    res_d.tx_level     = LvlW'(tx_fill_next);

    // ring writes only during execution
    if (state != S_EXEC) begin
      rx_we = 1'b0;
      tx_we = 1'b0;
    end
  end

  // state registers, updated on the execution cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      rx_head           <= '0;
      rx_tail           <= '0;
      rx_fill           <= '0;
      tx_head           <= '0;
      tx_tail           <= '0;
      tx_fill           <= '0;
      first_char_busy   <= 1'b0;
      pending_flow_byte <= '0;
      pending_valid     <= 1'b0;
      rx_pause_flag     <= 1'b0;
      tx_pause_flag     <= 1'b0;
      rts_state         <= 1'b1;
      sticky_errors     <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        rx_head           <= rx_head_next;
        rx_tail           <= rx_tail_next;
        rx_fill           <= rx_fill_next;
        tx_head           <= tx_head_next;
        tx_tail           <= tx_tail_next;
        tx_fill           <= tx_fill_next;
        first_char_busy   <= first_char_busy_next;
        pending_flow_byte <= pending_flow_byte_next;
        pending_valid     <= pending_valid_next;
        rx_pause_flag     <= rx_pause_flag_next;
        tx_pause_flag     <= tx_pause_flag_next;
        rts_state         <= rts_state_next;
        sticky_errors     <= sticky_errors_next;
      end
    end
  end

  // result queue
  assign res_push = (state == S_EXEC);
  assign res_pop  = pop && !empty;
  assign empty    = (res_cnt == 2'd0);
  assign result   = res_slot[res_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_slot[res_wr] <= res_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr  <= 1'b0;
      res_rd  <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr <= !res_wr;
      end
      if (res_pop) begin
        res_rd <= !res_rd;
      end
      res_cnt <= res_cnt + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

endmodule

[design/uart_fifo_flow_control.sv]
// uart_fifo_flow_control: top level of the serial port queue block with flow control
// depends on uff_pkg, uff_front, uff_back (which uses uff_ram)
`timescale 1ns / 1ps

// Usage:
// Input channel is a queue write side: present an event on item and raise push;
// the transaction is taken at a clock edge with push high and full low.
// Each event (line byte, host read, host write, transmitter done, flush)
// yields exactly one result transaction on the output queue read side: while
// empty is low the oldest result sits on result, and pop with empty low takes it.
// An event passes from the event queue through the idle state, which launches
// the registered read of the ring memories, and the exec state, which updates
// the state and queues the result; a new event is taken only after it leaves exec.
// A two entry event queue and a two entry result queue let the input side keep
// pushing while results wait; when the receiver stalls, execution stops once
// the result queue holds two transactions and full then rises.
// Configuration registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready, and should only change while no event is in flight.
// Reset (rst, synchronous) empties both rings and queues, asserts rts, clears
// errors and pause flags and loads the default flow codes and threshold.
module uart_fifo_flow_control #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  uff_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output uff_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uff_pkg::BYTE_W-1:0]    cfg_data
);

  logic          cmd_valid;
  uff_pkg::cmd_t cmd;
  logic          cmd_take;

  // event intake and decode
  uff_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // event execution and results
  uff_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[design/uff_checker.sv]
// uff_checker: port level checks of the serial port queue block, bound to the top
// depends on uff_pkg and uart_fifo_flow_control
`timescale 1ns / 1ps

module uff_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input uff_pkg::result_t result
);

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // send byte is zero when nothing goes out
  a_send_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.send_valid) |-> (result.send_byte == '0))
    else $error("send byte without send valid");

  // read byte is zero when a read found nothing
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.read_valid) |-> (result.read_byte == '0))
    else $error("read byte without read valid");

  // one event cannot both read and accept a write
  a_read_write_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(result.read_valid && result.write_accepted))
    else $error("read and write reported by one transaction");

endmodule

bind uart_fifo_flow_control uff_checker u_uff_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
